[rtl/core/fbik_pkg.sv]
// Shared constants, widths, types and the arctangent table of the leg solver.
`default_nettype none
package fbik_pkg;

  // Port widths.
  localparam int COORD_W   = 16;
  localparam int LEN_W     = 15;
  localparam int SERVO_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Internal datapath widths.
  localparam int PR_W   = 32;  // first products x*U, x*x and so on
  localparam int RS_W   = 34;  // x*x + y*y + U*U - W*W
  localparam int PQ_W   = 31;  // halved and quartered terms P, Q, R
  localparam int SQ_W   = 62;  // squares and the discriminant
  localparam int RAD_W  = 60;  // square root radicand
  localparam int ROOT_W = 30;  // square root result
  localparam int SQV_W  = 61;  // remainder and partial root inside the root unit
  localparam int NUM_W  = 32;  // arctangent numerator
  localparam int DEN_W  = 32;  // arctangent denominator
  localparam int X_W    = 36;  // rotator vector width
  localparam int Z_W    = 18;  // accumulated angle
  localparam int ANG_W  = 19;  // doubled angle, Q16 radians
  localparam int WANG_W = 21;  // angle after the wrap by two pi
  localparam int MAG_W  = 20;  // angle magnitude
  localparam int M_W    = 33;  // magnitude times 9000
  localparam int T_W    = 17;  // magnitude times 9000 over 65536
  localparam int RP_W   = 34;  // reciprocal product
  localparam int QT_W   = 10;  // quotient of the divide by 157
  localparam int DEG_W  = 11;  // signed whole degrees

  // Angle constants in Q16 radians.
  localparam int Q_PI     = 205887;
  localparam int Q_TWO_PI = 411775;
  localparam int Q_PI_4   = 51472;

  // Degree conversion: deg = angle * 9000 / (157 * 65536).
  localparam int DEG_MUL     = 9000;
  localparam int DEG_SHIFT   = 16;
  localparam int DEG_DIV     = 157;
  localparam int RECIP       = 106861;  // floor(2^24 / 157)
  localparam int RECIP_SHIFT = 24;

  // Servo offsets.
  localparam int SERVO_LEFT_BASE  = 90;
  localparam int SERVO_RIGHT_BASE = 270;

  // Pipeline depths.
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STAGES  = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int FRONT_LAT    = 4;
  localparam int NEG_DLY      = SQRT_STAGES + 1 + CORDIC_LAT;
  localparam int JOINT_LAT    = FRONT_LAT + NEG_DLY;
  localparam int DEG_LAT      = 3;
  localparam int TOTAL_LAT    = JOINT_LAT + 1 + DEG_LAT + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_THIGH = 2'd0,
    REG_FRONT_SHANK = 2'd1,
    REG_REAR_SHANK  = 2'd2,
    REG_REAR_THIGH  = 2'd3
  } cfg_reg_t;

  // atan(2^-i) in Q16, rounded.
  function automatic logic signed [Z_W-1:0] atan_tab(input int idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:       val = 18'sd51472;
      1:       val = 18'sd30386;
      2:       val = 18'sd16055;
      3:       val = 18'sd8150;
      4:       val = 18'sd4091;
      5:       val = 18'sd2047;
      6:       val = 18'sd1024;
      7:       val = 18'sd512;
      8:       val = 18'sd256;
      9:       val = 18'sd128;
      10:      val = 18'sd64;
      11:      val = 18'sd32;
      12:      val = 18'sd16;
      13:      val = 18'sd8;
      14:      val = 18'sd4;
      15:      val = 18'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

[rtl/core/fbik_in_if.sv]
// Request channel carrying the left and right foot targets.
`default_nettype none
interface fbik_in_if;
  import fbik_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_left;
  logic signed [COORD_W-1:0] y_left;
  logic signed [COORD_W-1:0] x_right;
  logic signed [COORD_W-1:0] y_right;

  modport source (output valid, x_left, y_left, x_right, y_right, input ready);
  modport sink   (input valid, x_left, y_left, x_right, y_right, output ready);
endinterface
`default_nettype wire

[rtl/core/fbik_out_if.sv]
// Result channel carrying the four servo commands and the reach flags.
`default_nettype none
interface fbik_out_if;
  import fbik_pkg::*;

  logic               valid;
  logic               ready;
  logic [SERVO_W-1:0] left_front_servo;
  logic [SERVO_W-1:0] left_rear_servo;
  logic [SERVO_W-1:0] right_front_servo;
  logic [SERVO_W-1:0] right_rear_servo;
  logic               left_unreachable;
  logic               right_unreachable;

  modport source (output valid, left_front_servo, left_rear_servo, right_front_servo,
                  right_rear_servo, left_unreachable, right_unreachable, input ready);
  modport sink   (input valid, left_front_servo, left_rear_servo, right_front_servo,
                  right_rear_servo, left_unreachable, right_unreachable, output ready);
endinterface
`default_nettype wire

[rtl/core/fbik_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module fbik_sqrt (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [fbik_pkg::RAD_W-1:0]   rad,
  output logic [fbik_pkg::ROOT_W-1:0]  root
);
  import fbik_pkg::*;

  logic [SQV_W-1:0] v_r [SQRT_STAGES];
  logic [SQV_W-1:0] r_r [SQRT_STAGES];

  for (genvar gi = 0; gi < SQRT_STAGES; gi++) begin : g_stage
    logic [SQV_W-1:0] v_in;
    logic [SQV_W-1:0] r_in;
    logic [SQV_W-1:0] bitv;
    logic [SQV_W-1:0] trial;
    logic [SQV_W-1:0] v_nxt;
    logic [SQV_W-1:0] r_nxt;

    if (gi == 0) begin : g_first
      assign v_in = SQV_W'(rad);
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = v_r[gi-1];
      assign r_in = r_r[gi-1];
    end

    // Test the next power of four against the remainder.
    assign bitv  = SQV_W'(1) << (2 * (SQRT_STAGES - 1 - gi));
    assign trial = r_in + bitv;
    assign v_nxt = (v_in >= trial) ? (v_in - trial) : v_in;
    assign r_nxt = (v_in >= trial) ? ((r_in >> 1) + bitv) : (r_in >> 1);

    always_ff @(posedge clk) begin
      if (adv) begin
        v_r[gi] <= v_nxt;
        r_r[gi] <= r_nxt;
      end
    end
  end

  assign root = r_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

[rtl/core/fbik_cordic.sv]
// Pipelined vectoring rotator giving twice the arctangent of num over den.
`default_nettype none
module fbik_cordic (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [fbik_pkg::NUM_W-1:0]  num,
  input  logic signed [fbik_pkg::DEN_W-1:0]  den,
  output logic signed [fbik_pkg::ANG_W-1:0]  ang
);
  import fbik_pkg::*;

  logic signed [X_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [X_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] z_r [CORDIC_STEPS+1];
  logic                  zero_r [CORDIC_STEPS+1];

  // Fold the vector into the right half plane.
  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r[0] <= (den == '0);
      x_r[0]    <= (den > 0) ? X_W'(den) : -X_W'(den);
      y_r[0]    <= (den > 0) ? X_W'(num) : -X_W'(num);
      z_r[0]    <= '0;
    end
  end

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;

    assign xs = x_r[gi] >>> gi;
    assign ys = y_r[gi] >>> gi;

    // Rotate toward the x axis and accumulate the angle.
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[gi+1] <= zero_r[gi];
        if (y_r[gi] >= 0) begin
          x_r[gi+1] <= x_r[gi] + ys;
          y_r[gi+1] <= y_r[gi] - xs;
          z_r[gi+1] <= z_r[gi] + atan_tab(gi);
        end else begin
          x_r[gi+1] <= x_r[gi] - ys;
          y_r[gi+1] <= y_r[gi] + xs;
          z_r[gi+1] <= z_r[gi] - atan_tab(gi);
        end
      end
    end
  end

  // A zero denominator gives pi.
  assign ang = zero_r[CORDIC_STEPS] ? ANG_W'(Q_PI) : $signed({z_r[CORDIC_STEPS], 1'b0});

endmodule
`default_nettype wire

[rtl/core/fbik_joint.sv]
// One joint: quadratic terms, discriminant root and both half-angle solutions.
`default_nettype none
module fbik_joint (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [fbik_pkg::COORD_W-1:0]  x,
  input  logic signed [fbik_pkg::COORD_W-1:0]  y,
  input  logic        [fbik_pkg::LEN_W-1:0]    up_len,
  input  logic        [fbik_pkg::LEN_W-1:0]    low_len,
  output logic signed [fbik_pkg::ANG_W-1:0]    sol1,
  output logic signed [fbik_pkg::ANG_W-1:0]    sol2,
  output logic                                 unreach
);
  import fbik_pkg::*;

  logic signed [COORD_W-1:0] up_s;
  logic signed [COORD_W-1:0] low_s;
  logic signed [PR_W-1:0]    xu_r, yu_r, xx_r, yy_r, uu_r, ww_r;
  logic signed [PR_W-1:0]    xu_adj, yu_adj;
  logic signed [RS_W-1:0]    r_sum, r_adj;
  logic signed [PQ_W-1:0]    p_r, q_r, rr_r;
  logic signed [SQ_W-1:0]    pp_r, qq_r, rsq_r;
  logic signed [PQ_W-1:0]    q_c_r;
  logic signed [DEN_W-1:0]   den_c_r;
  logic signed [SQ_W-1:0]    d_r;
  logic signed [PQ_W-1:0]    q_d_r;
  logic signed [DEN_W-1:0]   den_d_r;
  logic                      neg_d_r;
  logic [RAD_W-1:0]          rad;
  logic [ROOT_W-1:0]         root;
  logic signed [PQ_W-1:0]    q_line_r [SQRT_STAGES];
  logic signed [DEN_W-1:0]   den_line_r [SQRT_STAGES];
  logic                      neg_line_r [NEG_DLY];
  logic signed [NUM_W-1:0]   root_s;
  logic signed [NUM_W-1:0]   n1_r, n2_r;
  logic signed [DEN_W-1:0]   den_n_r;

  assign up_s  = $signed({1'b0, up_len});
  assign low_s = $signed({1'b0, low_len});

  // First products.
  always_ff @(posedge clk) begin
    if (adv) begin
      xu_r <= PR_W'(x) * PR_W'(up_s);
      yu_r <= PR_W'(y) * PR_W'(up_s);
      xx_r <= PR_W'(x) * PR_W'(x);
      yy_r <= PR_W'(y) * PR_W'(y);
      uu_r <= PR_W'(up_s) * PR_W'(up_s);
      ww_r <= PR_W'(low_s) * PR_W'(low_s);
    end
  end

  // Halve x*U and y*U and quarter the sum, rounding toward zero.
  assign xu_adj = xu_r + (xu_r[PR_W-1] ? PR_W'(1) : PR_W'(0));
  assign yu_adj = yu_r + (yu_r[PR_W-1] ? PR_W'(1) : PR_W'(0));
  assign r_sum  = RS_W'(xx_r) + RS_W'(yy_r) + RS_W'(uu_r) - RS_W'(ww_r);
  assign r_adj  = r_sum + (r_sum[RS_W-1] ? RS_W'(3) : RS_W'(0));

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= PQ_W'(xu_adj >>> 1);
      q_r  <= PQ_W'(yu_adj >>> 1);
      rr_r <= PQ_W'(r_adj >>> 2);
    end
  end

  // Squares and the arctangent denominator.
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r    <= SQ_W'(p_r) * SQ_W'(p_r);
      qq_r    <= SQ_W'(q_r) * SQ_W'(q_r);
      rsq_r   <= SQ_W'(rr_r) * SQ_W'(rr_r);
      q_c_r   <= q_r;
      den_c_r <= DEN_W'(p_r) + DEN_W'(rr_r);
    end
  end

  // Discriminant.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= pp_r + qq_r - rsq_r;
      neg_d_r <= (pp_r + qq_r) < rsq_r;
      q_d_r   <= q_c_r;
      den_d_r <= den_c_r;
    end
  end

  assign rad = neg_d_r ? '0 : d_r[RAD_W-1:0];

  fbik_sqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (rad),
    .root (root)
  );

  // Carry Q, the denominator and the reach flag alongside the root.
  always_ff @(posedge clk) begin
    if (adv) begin
      q_line_r[0]   <= q_d_r;
      den_line_r[0] <= den_d_r;
      neg_line_r[0] <= neg_d_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        q_line_r[i]   <= q_line_r[i-1];
        den_line_r[i] <= den_line_r[i-1];
      end
      for (int i = 1; i < NEG_DLY; i++) begin
        neg_line_r[i] <= neg_line_r[i-1];
      end
    end
  end

  // Both numerators.
  assign root_s = $signed(NUM_W'(root));

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r    <= NUM_W'(q_line_r[SQRT_STAGES-1]) + root_s;
      n2_r    <= NUM_W'(q_line_r[SQRT_STAGES-1]) - root_s;
      den_n_r <= den_line_r[SQRT_STAGES-1];
    end
  end

  fbik_cordic u_cordic1 (
    .clk (clk),
    .adv (adv),
    .num (n1_r),
    .den (den_n_r),
    .ang (sol1)
  );

  fbik_cordic u_cordic2 (
    .clk (clk),
    .adv (adv),
    .num (n2_r),
    .den (den_n_r),
    .ang (sol2)
  );

  assign unreach = neg_line_r[NEG_DLY-1];

endmodule
`default_nettype wire

[rtl/core/fbik_deg.sv]
// Radians in Q16 to whole degrees, truncated toward zero, in three stages.
`default_nettype none
module fbik_deg (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [fbik_pkg::WANG_W-1:0]  ang,
  output logic signed [fbik_pkg::DEG_W-1:0]   deg
);
  import fbik_pkg::*;

  logic [MAG_W-1:0]         mag;
  logic [M_W-1:0]           m_full;
  logic [T_W-1:0]           t1_r, t2_r;
  logic                     neg1_r, neg2_r;
  logic [RP_W-1:0]          prod_r;
  logic [QT_W-1:0]          q0;
  logic [T_W-1:0]           rem;
  logic [QT_W-1:0]          qt;
  logic signed [DEG_W-1:0]  deg_r;

  // Magnitude times 9000, then drop the 65536 factor.
  assign mag    = ang[WANG_W-1] ? MAG_W'(-ang) : MAG_W'(ang);
  assign m_full = M_W'(mag) * M_W'(DEG_MUL);

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1_r <= ang[WANG_W-1];
      t1_r   <= m_full[M_W-1:DEG_SHIFT];
    end
  end

  // Reciprocal estimate of the divide by 157.
  always_ff @(posedge clk) begin
    if (adv) begin
      neg2_r <= neg1_r;
      t2_r   <= t1_r;
      prod_r <= RP_W'(t1_r) * RP_W'(RECIP);
    end
  end

  // The estimate is low by at most one; correct it and restore the sign.
  assign q0  = prod_r[RECIP_SHIFT +: QT_W];
  assign rem = t2_r - T_W'(T_W'(q0) * T_W'(DEG_DIV));
  assign qt  = (rem >= T_W'(DEG_DIV)) ? (q0 + QT_W'(1)) : q0;

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r <= neg2_r ? -$signed(DEG_W'(qt)) : $signed(DEG_W'(qt));
    end
  end

  assign deg = deg_r;

endmodule
`default_nettype wire

[rtl/core/five_bar_leg_inverse_kinematics_unit.sv]
// Top level of the five-bar leg solver: pipeline control, angle selection, servo mapping.
//
// Usage: one request on in_ch carries the left and right foot targets (signed,
// 0.1 mm). One result on out_ch carries four servo commands in degrees and a
// per-leg unreachable flag; an unreachable leg gets zero servo commands.
// The four link lengths are written through cfg_we / cfg_index / cfg_wdata;
// the user must write them only while no request is in flight, which the
// block does not enforce. They reset to zero. A new request is taken every
// cycle unless a waiting result stalls the pipeline. The depth is set by the
// 30-stage square root and the 17-stage arctangent rotator in each joint,
// plus the degree conversion and the output register.
// All stages advance together: when the result waits with out_ch.ready low,
// the whole pipeline holds and in_ch.ready drops in the same cycle, so no
// request is lost or repeated. Reset empties the pipeline; results in flight
// are dropped.
`default_nettype none
module five_bar_leg_inverse_kinematics_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  fbik_in_if.sink                            in_ch,
  fbik_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [fbik_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbik_pkg::LEN_W-1:0]         cfg_wdata
);
  import fbik_pkg::*;

  logic                      adv;
  logic [TOTAL_LAT-1:0]      vld_r;
  logic [TOTAL_LAT-1:0]      vld_nxt;
  logic [LEN_W-1:0]          front_thigh_r, front_shank_r, rear_shank_r, rear_thigh_r;
  logic signed [DEG_W-1:0]   alpha_deg [2];
  logic signed [DEG_W-1:0]   beta_deg [2];
  logic                      unr_out [2];
  logic [SERVO_W-1:0]        lf_r, lr_r, rf_r, rr_r;
  logic                      lu_r, ru_r;

  // The pipeline moves whenever the output register is free or being drained.
  assign adv         = !vld_r[TOTAL_LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  assign vld_nxt = {vld_r[TOTAL_LAT-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Link length registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_thigh_r <= '0;
      front_shank_r <= '0;
      rear_shank_r  <= '0;
      rear_thigh_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRONT_THIGH: front_thigh_r <= cfg_wdata;
        REG_FRONT_SHANK: front_shank_r <= cfg_wdata;
        REG_REAR_SHANK:  rear_shank_r  <= cfg_wdata;
        REG_REAR_THIGH:  rear_thigh_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One solver per leg: left is index 0, right is index 1.
  for (genvar li = 0; li < 2; li++) begin : g_leg
    logic signed [COORD_W-1:0] lx, ly;
    logic signed [ANG_W-1:0]   a1, a2, b1, b2;
    logic                      ua, ub;
    logic signed [WANG_W-1:0]  a1w, a2w;
    logic signed [WANG_W-1:0]  alpha_nxt, beta_nxt;
    logic signed [WANG_W-1:0]  alpha_r, beta_r;
    logic                      unr_r;
    logic                      unr_line_r [DEG_LAT];

    if (li == 0) begin : g_left
      assign lx = in_ch.x_left;
      assign ly = in_ch.y_left;
    end else begin : g_right
      assign lx = in_ch.x_right;
      assign ly = in_ch.y_right;
    end

    fbik_joint u_alpha (
      .clk     (clk),
      .adv     (adv),
      .x       (lx),
      .y       (ly),
      .up_len  (front_thigh_r),
      .low_len (front_shank_r),
      .sol1    (a1),
      .sol2    (a2),
      .unreach (ua)
    );

    fbik_joint u_beta (
      .clk     (clk),
      .adv     (adv),
      .x       (lx),
      .y       (ly),
      .up_len  (rear_thigh_r),
      .low_len (rear_shank_r),
      .sol1    (b1),
      .sol2    (b2),
      .unreach (ub)
    );

    // Wrap alpha into one turn and pick the branch of each joint.
    assign a1w = (a1 < 0) ? (WANG_W'(a1) + WANG_W'(Q_TWO_PI)) : WANG_W'(a1);
    assign a2w = (a2 < 0) ? (WANG_W'(a2) + WANG_W'(Q_TWO_PI)) : WANG_W'(a2);
    assign alpha_nxt = (a1w >= WANG_W'(Q_PI_4)) ? a1w : a2w;
    assign beta_nxt  = (b1 >= 0 && b1 <= ANG_W'(Q_PI_4)) ? WANG_W'(b1) : WANG_W'(b2);

    always_ff @(posedge clk) begin
      if (adv) begin
        alpha_r <= alpha_nxt;
        beta_r  <= beta_nxt;
        unr_r   <= ua || ub;
      end
    end

    fbik_deg u_alpha_deg (
      .clk (clk),
      .adv (adv),
      .ang (alpha_r),
      .deg (alpha_deg[li])
    );

    fbik_deg u_beta_deg (
      .clk (clk),
      .adv (adv),
      .ang (beta_r),
      .deg (beta_deg[li])
    );

    // Keep the reach flag in step with the degree conversion.
    always_ff @(posedge clk) begin
      if (adv) begin
        unr_line_r[0] <= unr_r;
        for (int i = 1; i < DEG_LAT; i++) begin
          unr_line_r[i] <= unr_line_r[i-1];
        end
      end
    end

    assign unr_out[li] = unr_line_r[DEG_LAT-1];
  end

  // Servo mapping and output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      lf_r <= unr_out[0] ? '0 : SERVO_W'(SERVO_LEFT_BASE) + SERVO_W'(beta_deg[0]);
      lr_r <= unr_out[0] ? '0 : SERVO_W'(SERVO_LEFT_BASE) + SERVO_W'(alpha_deg[0]);
      rf_r <= unr_out[1] ? '0 : SERVO_W'(SERVO_RIGHT_BASE) - SERVO_W'(beta_deg[1]);
      rr_r <= unr_out[1] ? '0 : SERVO_W'(SERVO_RIGHT_BASE) - SERVO_W'(alpha_deg[1]);
      lu_r <= unr_out[0];
      ru_r <= unr_out[1];
    end
  end

  assign out_ch.valid             = vld_r[TOTAL_LAT-1];
  assign out_ch.left_front_servo  = lf_r;
  assign out_ch.left_rear_servo   = lr_r;
  assign out_ch.right_front_servo = rf_r;
  assign out_ch.right_rear_servo  = rr_r;
  assign out_ch.left_unreachable  = lu_r;
  assign out_ch.right_unreachable = ru_r;

  // An unreachable left leg must come out with both of its servos at zero.
  a_left_unr_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.left_unreachable |->
      out_ch.left_front_servo == '0 && out_ch.left_rear_servo == '0)
    else $error("left leg flagged unreachable with nonzero servos");

  // The same for the right leg.
  a_right_unr_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.right_unreachable |->
      out_ch.right_front_servo == '0 && out_ch.right_rear_servo == '0)
    else $error("right leg flagged unreachable with nonzero servos");

  // A stalled pipeline keeps every request where it is.
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved while the pipeline was stalled");

  // Reset leaves no result on the output.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result present right after reset");

endmodule
`default_nettype wire
